### hw/rtl/lfhwe_pkg.sv
// Shared types, constants and command/status structs of the LED frame hue wheel engine.
`default_nettype none

package lfhwe_pkg;

   localparam int PIXEL_COUNT = 64;
   localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int CNT_W       = $clog2(PIXEL_COUNT + 1);

   localparam logic [2:0] OP_WRITE   = 3'd0;
   localparam logic [2:0] OP_FILL    = 3'd1;
   localparam logic [2:0] OP_RAINBOW = 3'd2;
   localparam logic [2:0] OP_ADVANCE = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // channel 0 red, 1 green, 2 blue
   typedef logic [2:0][7:0] pixel_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [5:0] pixel_index;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] hue_step;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_ADV
   } fsm_state_type;

   typedef struct packed {
      logic accept;
      logic wr_single;
      logic fill_run;
      logic adv_run;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_last;
      logic walk_end;
      logic rsp_busy;
   } dp_sts_type;

endpackage

`default_nettype wire

### hw/rtl/lfhwe_ctrl.sv
// Operation sequencer: decodes accepted items and steps the fill, advance and read passes.
`default_nettype none

module lfhwe_ctrl
   import lfhwe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_opcode,
   output logic            req_ready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // hold a read back while the result slot is still occupied
            req_ready  = !(req_opcode == OP_READ && sts.rsp_busy);
            cmd.accept = req_valid && req_ready;
            if (cmd.accept) begin
               case (req_opcode)
                  OP_WRITE:            cmd.wr_single = 1'b1;
                  OP_FILL, OP_RAINBOW: state_in = ST_FILL;
                  OP_ADVANCE:          state_in = ST_ADV;
                  OP_READ:             state_in = ST_READ;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_run = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ADV: begin
            cmd.adv_run = 1'b1;
            if (sts.walk_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/lfhwe_dpath.sv
// Frame store, sweep counter, wheel step unit and result register.
`default_nettype none

module lfhwe_dpath
   import lfhwe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire dp_cmd_type cmd,
   output dp_sts_type      sts,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   function automatic pixel_type wheel_step(input pixel_type px, input logic [7:0] step);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [1:0] up;
      logic [1:0] dn;
      logic       rising;
      logic       on_wheel;
      logic [7:0] v;
      logic [7:0] o;
      logic [8:0] sum;
      pixel_type  res;
      r        = px[CH_RED];
      g        = px[CH_GREEN];
      b        = px[CH_BLUE];
      res      = px;
      up       = CH_RED;
      dn       = CH_RED;
      rising   = 1'b0;
      on_wheel = 1'b1;
      if (r == 8'hFF && g != 8'hFF && b == 8'h00) begin
         up = CH_GREEN; dn = CH_RED;   rising = 1'b1;
      end else if (r != 8'h00 && g == 8'hFF && b == 8'h00) begin
         up = CH_RED;   dn = CH_BLUE;  rising = 1'b0;
      end else if (r == 8'h00 && g == 8'hFF && b != 8'hFF) begin
         up = CH_BLUE;  dn = CH_GREEN; rising = 1'b1;
      end else if (r == 8'h00 && g != 8'h00 && b == 8'hFF) begin
         up = CH_GREEN; dn = CH_RED;   rising = 1'b0;
      end else if (r != 8'hFF && g == 8'h00 && b == 8'hFF) begin
         up = CH_RED;   dn = CH_BLUE;  rising = 1'b1;
      end else if (r == 8'hFF && g == 8'h00 && b != 8'h00) begin
         up = CH_BLUE;  dn = CH_GREEN; rising = 1'b0;
      end else begin
         on_wheel = 1'b0;
      end
      v   = px[up];
      o   = px[dn];
      sum = {1'b0, v} + {1'b0, step};
      if (!on_wheel) begin
         res[CH_RED] = 8'hFF;
      end else if (rising) begin
         if (sum <= 9'd255) begin
            res[up] = sum[7:0];
         end else begin
            // excess over the stage end is sum - 255, i.e. sum + 1 modulo 256
            res[dn] = o - (sum[7:0] + 8'd1);
            res[up] = 8'hFF;
         end
      end else begin
         if (v >= step) begin
            res[up] = v - step;
         end else begin
            res[dn] = o + (step - v);
            res[up] = 8'h00;
         end
      end
      return res;
   endfunction

   pixel_type              mem_ff [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] valid_ff;
   pixel_type              rd_data_ff;
   logic                   rd_valid_ff;
   logic [ADDR_W-1:0]      rd_addr_ff;
   logic [CNT_W-1:0]       walk_ff;
   logic [CNT_W-1:0]       walk_in;
   pixel_type              color_ff;
   pixel_type              color_in;
   logic [7:0]             step_ff;
   logic                   rainbow_ff;
   logic                   read_hit_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;

   logic                   idx_hit;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   pixel_type              wr_data;
   pixel_type              rd_pixel;
   pixel_type              req_pixel;

   assign idx_hit   = 32'(req_data.pixel_index) < 32'(PIXEL_COUNT);
   assign req_pixel = {req_data.blue_in, req_data.green_in, req_data.red_in};
   assign rd_pixel  = rd_valid_ff ? rd_data_ff : '0;

   assign sts.walk_last = walk_ff == CNT_W'(PIXEL_COUNT - 1);
   assign sts.walk_end  = walk_ff == CNT_W'(PIXEL_COUNT);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rd_addr = cmd.adv_run ? walk_ff[ADDR_W-1:0] : ADDR_W'(req_data.pixel_index);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = walk_ff[ADDR_W-1:0];
      wr_data = color_ff;
      if (cmd.fill_run) begin
         wr_en = 1'b1;
      end else if (cmd.adv_run) begin
         // write back the pixel read in the previous cycle
         wr_en   = walk_ff != '0;
         wr_addr = rd_addr_ff;
         wr_data = wheel_step(rd_pixel, step_ff);
      end else if (cmd.wr_single) begin
         wr_en   = idx_hit;
         wr_addr = ADDR_W'(req_data.pixel_index);
         wr_data = req_pixel;
      end
   end

   always_comb begin
      walk_in  = walk_ff;
      color_in = color_ff;
      if (cmd.accept) begin
         walk_in  = '0;
         color_in = (req_data.opcode == OP_RAINBOW) ? pixel_type'({8'h00, 8'h00, 8'hFF})
                                                    : req_pixel;
      end else if (cmd.fill_run) begin
         walk_in = sts.walk_last ? '0 : walk_ff + 1'b1;
         if (rainbow_ff) begin
            color_in = wheel_step(color_ff, step_ff);
         end
      end else if (cmd.adv_run) begin
         walk_in = sts.walk_end ? '0 : walk_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
      color_ff    <= color_in;
      if (cmd.accept) begin
         step_ff     <= req_data.hue_step;
         rainbow_ff  <= req_data.opcode == OP_RAINBOW;
         read_hit_ff <= idx_hit;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.red_out   <= read_hit_ff ? rd_pixel[CH_RED]   : 8'h00;
         rsp_data_ff.green_out <= read_hit_ff ? rd_pixel[CH_GREEN] : 8'h00;
         rsp_data_ff.blue_out  <= read_hit_ff ? rd_pixel[CH_BLUE]  : 8'h00;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/led_frame_hue_wheel_engine.sv
// LED frame hue wheel engine: RGB frame store with fill, rainbow, hue advance and pixel read.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one operation per item:
//   write pixel, fill color, fill rainbow, advance all, read pixel.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one item per read pixel.
//   Write pixel:   the next item can follow at once.
//   Read pixel:    result registered in the cycle after accept; req_ready drops for 1 cycle.
//   Fill color and fill rainbow: one store write per cycle across all PIXEL_COUNT pixels (64).
//   Advance all:   the single store read port and write port form a
//                  read-modify-write pipeline, one pixel per cycle.
//   req_ready stays low for the length of each pass.
//   Reset clears the sequencer and marks every pixel as black at once through
//   per-pixel valid flags; no clearing pass is needed.
//   A pending result sits in the output register while other items are taken;
//   only a new read is held back until the receiver takes the pending result.
`default_nettype none

module led_frame_hue_wheel_engine
   import lfhwe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   lfhwe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lfhwe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_read_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == OP_READ) |=> cmd.rsp_load)
      else $error("accepted read did not load the result register");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid)
      else $error("result register loaded while a result is pending");

   a_busy_during_pass: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_run || cmd.adv_run) |-> !req_ready)
      else $error("item accepted during a store pass");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_single, cmd.fill_run, cmd.adv_run, cmd.rsp_load}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench of the LED frame hue wheel engine, with its own frame store predictor.
`default_nettype none

module testbench;
   import lfhwe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PASS_LATENCY = 100;
   localparam int MAX_SHOWN    = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predicted frame and the reads still owed by the block
   pixel_type frame_model [PIXEL_COUNT];
   rsp_type   pending_reads [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_count    = 0;
   int items_sent    = 0;
   int reads_checked = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   led_frame_hue_wheel_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Move one color along the six-stage wheel by step.
   function automatic pixel_type hue_rotate(pixel_type px, logic [7:0] step);
      int unsigned r = px[CH_RED];
      int unsigned g = px[CH_GREEN];
      int unsigned b = px[CH_BLUE];
      int          v;
      int          o;
      logic [1:0]  up;
      logic [1:0]  dn;
      bit          rising;
      if (r == 255 && g != 255 && b == 0) begin
         up = CH_GREEN; dn = CH_RED;   rising = 1'b1;
      end else if (r != 0 && g == 255 && b == 0) begin
         up = CH_RED;   dn = CH_BLUE;  rising = 1'b0;
      end else if (r == 0 && g == 255 && b != 255) begin
         up = CH_BLUE;  dn = CH_GREEN; rising = 1'b1;
      end else if (r == 0 && g != 0 && b == 255) begin
         up = CH_GREEN; dn = CH_RED;   rising = 1'b0;
      end else if (r != 255 && g == 0 && b == 255) begin
         up = CH_RED;   dn = CH_BLUE;  rising = 1'b1;
      end else if (r == 255 && g == 0 && b != 0) begin
         up = CH_BLUE;  dn = CH_GREEN; rising = 1'b0;
      end else begin
         // off the wheel: force red to full and stop
         px[CH_RED] = 8'hFF;
         return px;
      end
      v = px[up];
      o = px[dn];
      if (rising) begin
         if (v + step <= 255) begin
            px[up] = 8'(v + step);
         end else begin
            px[dn] = 8'(o - (step - (255 - v)));
            px[up] = 8'hFF;
         end
      end else begin
         if (v >= step) begin
            px[up] = 8'(v - step);
         end else begin
            px[dn] = 8'(o + (step - v));
            px[up] = 8'h00;
         end
      end
      return px;
   endfunction

   // Update the frame model for one accepted item; queue the read it owes.
   function automatic void update_frame(req_type it);
      pixel_type color;
      rsp_type   owed;
      color[CH_RED]   = it.red_in;
      color[CH_GREEN] = it.green_in;
      color[CH_BLUE]  = it.blue_in;
      case (it.opcode)
         OP_WRITE: begin
            if (int'(it.pixel_index) < PIXEL_COUNT) frame_model[it.pixel_index] = color;
         end
         OP_FILL: begin
            foreach (frame_model[i]) frame_model[i] = color;
         end
         OP_RAINBOW: begin
            frame_model[0] = '0;
            frame_model[0][CH_RED] = 8'hFF;
            for (int i = 1; i < PIXEL_COUNT; i++)
               frame_model[i] = hue_rotate(frame_model[i-1], it.hue_step);
         end
         OP_ADVANCE: begin
            foreach (frame_model[i]) frame_model[i] = hue_rotate(frame_model[i], it.hue_step);
         end
         OP_READ: begin
            owed = '0;
            if (int'(it.pixel_index) < PIXEL_COUNT) begin
               owed.red_out   = frame_model[it.pixel_index][CH_RED];
               owed.green_out = frame_model[it.pixel_index][CH_GREEN];
               owed.blue_out  = frame_model[it.pixel_index][CH_BLUE];
            end
            pending_reads.push_back(owed);
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [5:0] idx, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, logic [7:0] step);
      req_type it;
      it.opcode      = op;
      it.pixel_index = idx;
      it.red_in      = r;
      it.green_in    = g;
      it.blue_in     = b;
      it.hue_step    = step;
      return it;
   endfunction

   // Mostly on-wheel colors, so advances walk the stages instead of sticking off-wheel.
   function automatic pixel_type random_color();
      pixel_type   px;
      logic [7:0]  m;
      m  = 8'($urandom_range(0, 255));
      px = '0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            case ($urandom_range(0, 5))
               0: begin px[CH_RED] = 8'hFF; px[CH_GREEN] = m; end
               1: begin px[CH_RED] = m; px[CH_GREEN] = 8'hFF; end
               2: begin px[CH_GREEN] = 8'hFF; px[CH_BLUE] = m; end
               3: begin px[CH_GREEN] = m; px[CH_BLUE] = 8'hFF; end
               4: begin px[CH_RED] = m; px[CH_BLUE] = 8'hFF; end
               default: begin px[CH_RED] = 8'hFF; px[CH_BLUE] = m; end
            endcase
         end
         5, 6: begin
            foreach (px[c]) px[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: px = 24'($urandom);
      endcase
      return px;
   endfunction

   function automatic logic [7:0] random_step();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2, 3:    return 8'($urandom_range(1, 8));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type random_req();
      pixel_type  color;
      logic [2:0] op;
      int         pick;
      color = random_color();
      pick  = $urandom_range(0, 99);
      if (pick < 45)      op = OP_READ;
      else if (pick < 72) op = OP_WRITE;
      else if (pick < 80) op = OP_FILL;
      else if (pick < 88) op = OP_RAINBOW;
      else if (pick < 97) op = OP_ADVANCE;
      else                op = 3'($urandom_range(5, 7));
      return make_req(op, 6'($urandom_range(0, 63)), color[CH_RED], color[CH_GREEN],
                      color[CH_BLUE], random_step());
   endfunction

   // Offer one item, idling at random first; valid stays high until the item is taken.
   task automatic send_item(input req_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      update_frame(it);
      items_sent++;
   endtask

   // Drop valid and hold until every owed read has come back.
   task automatic wait_reads_done();
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(make_req(OP_READ,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_READ,  6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_req(OP_WRITE, 6'd0,  8'hFF, 8'hFF, 8'hFF, 8'h00));
      send_item(make_req(OP_WRITE, 6'd63, 8'hFF, 8'h00, 8'h00, 8'hFF));
      send_item(make_req(OP_READ,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00));
      // zero step: black pixels still get red forced, white stays off-wheel
      send_item(make_req(OP_ADVANCE, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_READ,  6'd1,  8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_READ,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_ADVANCE, 6'd0, 8'h00, 8'h00, 8'h00, 8'hFF));
      send_item(make_req(OP_READ,  6'd63, 8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_RAINBOW, 6'd0, 8'h00, 8'h00, 8'h00, 8'd43));
      send_item(make_req(OP_READ,  6'd1,  8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_READ,  6'd63, 8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_RAINBOW, 6'd0, 8'h00, 8'h00, 8'h00, 8'hFF));
      send_item(make_req(OP_READ,  6'd5,  8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_RAINBOW, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(OP_READ,  6'd40, 8'h00, 8'h00, 8'h00, 8'h00));
      // pure blue raised past full red carries into blue
      send_item(make_req(OP_FILL,  6'd0,  8'h00, 8'h00, 8'hFF, 8'h00));
      send_item(make_req(OP_ADVANCE, 6'd0, 8'h00, 8'h00, 8'h00, 8'd200));
      send_item(make_req(OP_ADVANCE, 6'd0, 8'h00, 8'h00, 8'h00, 8'd100));
      send_item(make_req(OP_READ,  6'd7,  8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_req(3'd5,     6'd9,  8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_req(3'd6,     6'd9,  8'hAA, 8'h55, 8'hAA, 8'h55));
      send_item(make_req(3'd7,     6'd9,  8'h55, 8'hAA, 8'h55, 8'hAA));
      send_item(make_req(OP_READ,  6'd9,  8'h00, 8'h00, 8'h00, 8'h00));
      wait_reads_done();
   endtask

   // Receiver stops for a long stretch while reads keep coming, so the input stalls.
   task automatic test_receiver_hold();
      req_type it;
      hold_request = 400;
      for (int n = 0; n < 30; n++) begin
         it = random_req();
         if (n % 2 == 0) it.opcode = OP_READ;
         send_item(it);
      end
      wait_reads_done();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         send_item(random_req());
         // now and then stop sending until every read is back
         if ($urandom_range(0, 99) == 0) wait_reads_done();
      end
      wait_reads_done();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_count   = hold_request;
            hold_request = 0;
         end
         if (hold_count > 0) begin
            hold_count = hold_count - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("ERROR: unexpected pixel read %h/%h/%h", rsp_data.red_out,
                        rsp_data.green_out, rsp_data.blue_out);
         end else begin
            want = pending_reads.pop_front();
            reads_checked++;
            if (rsp_data.red_out != want.red_out || rsp_data.green_out != want.green_out ||
                rsp_data.blue_out != want.blue_out) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("ERROR: read %0d expected rgb %h/%h/%h got %h/%h/%h",
                           reads_checked, want.red_out, want.green_out, want.blue_out,
                           rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (frame_model[i]) frame_model[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_receiver_hold();
      test_random(340, 33, 51);
      test_random(340, 51, 33);
      test_random(340, 0, 0);
      repeat (PASS_LATENCY) @(posedge clock);
      if (pending_reads.size() != 0) begin
         mismatches++;
         $display("ERROR: %0d pixel reads never returned", pending_reads.size());
      end
      $display("Sent %0d items through directed, stalled-receiver and random phases;",
               items_sent);
      $display("checked %0d pixel reads, %0d mismatches.", reads_checked, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
